// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the converter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nfc_pkg.sv -----
// Package for the narrow float converter: operation codes, format constants
// and the input beat type. No dependencies.
package nfc_pkg;

    localparam logic [1:0] FUNC_BF16_TO_F32 = 2'd0;
    localparam logic [1:0] FUNC_F16_TO_F32  = 2'd1;
    localparam logic [1:0] FUNC_F32_TO_BF16 = 2'd2;
    localparam logic [1:0] FUNC_F32_TO_F16  = 2'd3;

    localparam logic [30:0] F32_INF_MAG  = 31'h7F800000;
    localparam logic [30:0] F16_OVF_AT   = 31'h477FF000;
    localparam logic [30:0] F16_UNF_AT   = 31'h33000000;
    localparam logic [14:0] F16_INF      = 15'h7C00;
    localparam logic [14:0] F16_QNAN_BIT = 15'h0200;
    localparam logic [7:0]  BIAS_DIFF    = 8'd112;
    localparam logic [7:0]  SUBN_EXP_TOP = 8'd113;
    localparam logic [7:0]  SUBN_SHIFT_K = 8'd126;
    localparam logic [4:0]  NORM_SHIFT   = 5'd13;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] narrow_value;
        logic [31:0] wide_value;
    } beat_t;

endpackage

// ----- hdl/nfc_widen.sv -----
// Widening to binary32 from bfloat16 or binary16.
// Depends on nfc_pkg.
module nfc_widen (
    input  logic        is_half,
    input  logic [15:0] narrow_value,
    output logic [31:0] result_bits
);

    logic        sign;
    logic [4:0]  exp_h;
    logic [9:0]  mant_h;
    logic [3:0]  lead_pos;
    logic [3:0]  norm_shift;
    logic [10:0] norm;
    logic [31:0] half_bits;

    assign sign   = narrow_value[15];
    assign exp_h  = narrow_value[14:10];
    assign mant_h = narrow_value[9:0];

    always_comb begin
        lead_pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mant_h[i]) begin
                lead_pos = 4'(i);
            end
        end
    end

    // shift that brings the leading one to bit 10
    assign norm_shift = 4'd10 - lead_pos;
    assign norm       = {1'b0, mant_h} << norm_shift;

    always_comb begin
        if (exp_h == 5'h1F) begin
            half_bits = {sign, 8'hFF, mant_h, 13'd0};
        end else if (exp_h != 5'd0) begin
            half_bits = {sign, {3'd0, exp_h} + nfc_pkg::BIAS_DIFF, mant_h, 13'd0};
        end else if (mant_h == 10'd0) begin
            half_bits = {sign, 31'd0};
        end else begin
            half_bits = {sign, nfc_pkg::SUBN_EXP_TOP - {4'd0, norm_shift},
                         norm[9:0], 13'd0};
        end
    end

    assign result_bits = is_half ? half_bits : {narrow_value, 16'd0};

endmodule

// ----- hdl/nfc_narrow.sv -----
// Narrowing from binary32 to bfloat16 or binary16, round to nearest even.
// Depends on nfc_pkg.
module nfc_narrow (
    input  logic        is_half,
    input  logic [31:0] wide_value,
    output logic [31:0] result_bits
);

    logic        sign;
    logic [30:0] mag;
    logic [15:0] hi;
    logic [15:0] lo;
    logic        keep_nan;
    logic        bf_up;
    logic [15:0] bf_bits;

    logic [7:0]  exp_f;
    logic [23:0] mant;
    logic        is_norm;
    logic [4:0]  shift;
    logic [4:0]  guard_idx;
    logic [23:0] sticky_mask;
    logic        guard;
    logic        sticky;
    logic [15:0] h_trunc;
    logic        h_up;
    logic [15:0] h_round;
    logic [15:0] half_bits;

    assign sign = wide_value[31];
    assign mag  = wide_value[30:0];
    assign hi   = wide_value[31:16];
    assign lo   = wide_value[15:0];

    // bfloat16
    assign keep_nan = (wide_value[22:0] != 23'd0) && (hi[6:0] == 7'd0);
    assign bf_up    = (lo > 16'h8000) || ((lo == 16'h8000) && hi[0]);
    always_comb begin
        if (wide_value[30:23] == 8'hFF) begin
            bf_bits = hi | {15'd0, keep_nan};
        end else begin
            bf_bits = hi + {15'd0, bf_up};
        end
    end

    // binary16
    assign exp_f       = mag[30:23];
    assign mant        = {1'b1, mag[22:0]};
    assign is_norm     = exp_f >= nfc_pkg::SUBN_EXP_TOP;
    assign shift       = is_norm ? nfc_pkg::NORM_SHIFT : 5'(nfc_pkg::SUBN_SHIFT_K - exp_f);
    assign guard_idx   = shift - 5'd1;
    assign sticky_mask = (24'd1 << guard_idx) - 24'd1;
    assign guard       = mant[guard_idx];
    assign sticky      = (mant & sticky_mask) != 24'd0;

    always_comb begin
        if (is_norm) begin
            h_trunc = {1'b0, 5'(exp_f - nfc_pkg::BIAS_DIFF), mant[22:13]};
        end else begin
            h_trunc = 16'(mant >> shift);
        end
    end

    assign h_up    = guard && (sticky || h_trunc[0]);
    assign h_round = h_trunc + {15'd0, h_up};

    always_comb begin
        if (mag >= nfc_pkg::F32_INF_MAG) begin
            half_bits = {sign, nfc_pkg::F16_INF
                         | ((mag > nfc_pkg::F32_INF_MAG) ? nfc_pkg::F16_QNAN_BIT : 15'd0)};
        end else if (mag >= nfc_pkg::F16_OVF_AT) begin
            half_bits = {sign, nfc_pkg::F16_INF};
        end else if (mag <= nfc_pkg::F16_UNF_AT) begin
            half_bits = {sign, 15'd0};
        end else begin
            half_bits = {sign, h_round[14:0]};
        end
    end

    assign result_bits = {16'd0, is_half ? half_bits : bf_bits};

endmodule

// ----- hdl/narrow_float_converter.sv -----
// Usage: converts bit patterns between binary32, bfloat16 and binary16.
// Input channel s_*: one beat carries s_func (0 bf16->f32, 1 f16->f32,
// 2 f32->bf16, 3 f32->f16), s_narrow_value and s_wide_value.
// Result channel m_*: one beat carries m_result_bits; 16-bit results are
// zero-extended. Every input beat yields exactly one result beat, in order.
// An input beat accepted on s_* is registered, converted and registered again
// before it is presented on m_* (two register stages).
// Throughput: one beat per cycle unless m_ready stalls; the conversion is a
// single combinational pass between the input and the result registers.
// Stall: when m_ready is low with a result waiting, an empty input register
// still takes one more beat; then s_ready drops until the result drains.
// s_ready depends combinationally on m_ready.
// Reset (aresetn low, synchronous): both stages are emptied, m_valid low.
// Depends on nfc_pkg, nfc_widen, nfc_narrow and assert_macros.svh.
`include "assert_macros.svh"

module narrow_float_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_narrow_value,
    input  logic [31:0] s_wide_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_bits
);

    nfc_pkg::beat_t in_beat_reg;
    logic           in_vld_reg;
    logic           out_vld_reg;
    logic [31:0]    out_bits_reg;
    logic           in_en;
    logic           out_en;
    logic [31:0]    widen_bits;
    logic [31:0]    narrow_bits;
    logic [31:0]    result_next;

    assign out_en  = !out_vld_reg || m_ready;
    assign in_en   = !in_vld_reg || out_en;
    assign s_ready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            in_beat_reg.func         <= s_func;
            in_beat_reg.narrow_value <= s_narrow_value;
            in_beat_reg.wide_value   <= s_wide_value;
        end
    end

    nfc_widen u_widen (
        .is_half      (in_beat_reg.func == nfc_pkg::FUNC_F16_TO_F32),
        .narrow_value (in_beat_reg.narrow_value),
        .result_bits  (widen_bits)
    );

    nfc_narrow u_narrow (
        .is_half     (in_beat_reg.func == nfc_pkg::FUNC_F32_TO_F16),
        .wide_value  (in_beat_reg.wide_value),
        .result_bits (narrow_bits)
    );

    always_comb begin
        case (in_beat_reg.func)
            nfc_pkg::FUNC_BF16_TO_F32, nfc_pkg::FUNC_F16_TO_F32: begin
                result_next = widen_bits;
            end
            default: begin
                result_next = narrow_bits;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_en) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && in_vld_reg) begin
            out_bits_reg <= result_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_result_bits = out_bits_reg;

    `NFC_ASSERT_SAME(a_ready_when_drained, aclk, aresetn, m_ready, s_ready, "s_ready low while m_ready high")
    `NFC_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_valid && s_ready, in_vld_reg, "accepted beat lost at input stage")
    `NFC_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, in_vld_reg && out_en, m_valid, "beat lost between stages")
    `NFC_ASSERT_NEXT(a_stalled_input_holds, aclk, aresetn, in_vld_reg && !out_en, in_vld_reg && $stable(in_beat_reg), "stalled input stage changed")

endmodule
